// ===== rtl/tkgr_pkg.sv =====
// Shared types and constants for the top-k gated router.
// Holds word layouts, operation and register codes, the FSM state type and
// the command and status structs between the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package tkgr_pkg;

  // Field widths of the input and output words.
  localparam int AREA_W  = 6;
  localparam int SCORE_W = 7;
  localparam int PROBE_W = 64;

  // Input tdata layout, lowest bits first.
  localparam int SRC_LSB    = 0;
  localparam int TGT_LSB    = SRC_LSB + AREA_W;
  localparam int GATE_BIT   = TGT_LSB + AREA_W;
  localparam int PROBE_LSB  = GATE_BIT + 1;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // Operation carried in tuser.
  typedef enum logic [0:0] {
    OP_SET   = 1'b0,
    OP_ROUTE = 1'b1
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AREAS_USED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FANOUT     = 4'd1;

  localparam logic [6:0] AREAS_USED_RST = 7'd64;
  localparam logic [3:0] FANOUT_RST     = 4'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the accepted input word
    logic list_clr;  // start a route: empty the list, rewind counters
    logic rd_set;    // read the mask addressed by a set word
    logic wr_set;    // write back the modified mask
    logic rd_scan;   // read the next area mask of a route
    logic emit_adv;  // a result word was taken
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_ok;     // set word addresses an existing area
    logic route_none; // route has no areas or no fanout
    logic scan_last;  // current scan read is the last area
    logic pipe_busy;  // scores still in flight
    logic list_empty; // nothing kept
    logic emit_last;  // current result word is the final one
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tkgr_ctrl.sv =====
// Controller state machine of the top-k gated router.
// Sequences set words, route scans, pipeline drain and result emission.
// Depends on tkgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkgr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          in_op,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire tkgr_pkg::sts_t sts,
  output tkgr_pkg::cmd_t     cmd
);

  import tkgr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (op_t'(in_op) == OP_ROUTE) begin
            cmd.list_clr = 1'b1;
            state_nxt    = sts.route_none ? S_IDLE : S_SCAN;
          end else begin
            state_nxt = S_SET_RD;
          end
        end
      end
      S_SET_RD: begin
        // An out-of-range area leaves every mask alone.
        if (sts.src_ok) begin
          cmd.rd_set = 1'b1;
          state_nxt  = S_SET_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SET_WR: begin
        cmd.wr_set = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = sts.list_empty ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tkgr_datapath.sv =====
// Datapath of the top-k gated router: gate mask memory, popcount pipeline,
// sorted kept list and result word mux. Depends on tkgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkgr_datapath #(
  parameter int AREA_COUNT = 64,
  parameter int FANOUT_MAX = 8,
  localparam int AW  = $clog2(AREA_COUNT + 1),
  localparam int CW  = $clog2(FANOUT_MAX + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [tkgr_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [AW-1:0]                  limit,
  input  wire logic [CW-1:0]                  cap,
  input  wire tkgr_pkg::cmd_t                 cmd,
  output tkgr_pkg::sts_t                      sts,
  output logic [tkgr_pkg::AREA_W-1:0]         res_area,
  output logic [tkgr_pkg::SCORE_W-1:0]        res_score
);

  import tkgr_pkg::*;

  localparam int IW  = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;
  localparam int LIW = (FANOUT_MAX > 1) ? $clog2(FANOUT_MAX) : 1;

  // Captured input word.
  logic [AREA_W-1:0]  src_r;
  logic [AREA_W-1:0]  tgt_r;
  logic               gate_on_r;
  logic [PROBE_W-1:0] probe_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      src_r     <= in_tdata[SRC_LSB +: AREA_W];
      tgt_r     <= in_tdata[TGT_LSB +: AREA_W];
      gate_on_r <= in_tdata[GATE_BIT];
      probe_r   <= in_tdata[PROBE_LSB +: PROBE_W];
    end
  end

  // Gate mask memory; an entry never written reads as zero via its valid bit.
  logic [PROBE_W-1:0] gate_mem [AREA_COUNT];
  logic               gate_vld_r [AREA_COUNT];
  logic [PROBE_W-1:0] rdata_r;
  logic               rd_vld_r;
  logic [PROBE_W-1:0] mask_eff;
  logic [PROBE_W-1:0] wdata;
  logic [IW-1:0]      raddr;
  logic [AW-1:0]      scan_cnt_r;

  assign raddr    = cmd.rd_set ? src_r[IW-1:0] : scan_cnt_r[IW-1:0];
  assign mask_eff = rd_vld_r ? rdata_r : '0;
  assign wdata    = gate_on_r ? (mask_eff | (PROBE_W'(1) << tgt_r))
                              : (mask_eff & ~(PROBE_W'(1) << tgt_r));

  always_ff @(posedge clk) begin
    if (cmd.wr_set) begin
      gate_mem[src_r[IW-1:0]] <= wdata;
    end
    if (cmd.rd_set || cmd.rd_scan) begin
      rdata_r  <= gate_mem[raddr];
      rd_vld_r <= gate_vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AREA_COUNT; i++) begin
        gate_vld_r[i] <= 1'b0;
      end
    end else if (cmd.wr_set) begin
      gate_vld_r[src_r[IW-1:0]] <= 1'b1;
    end
  end

  // Scan counter walks areas 0 .. limit-1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (cmd.list_clr) begin
      scan_cnt_r <= '0;
    end else if (cmd.rd_scan) begin
      scan_cnt_r <= scan_cnt_r + AW'(1);
    end
  end

  // Score pipeline: read, per-byte popcount, byte sum.
  logic               p1_v_r;
  logic               p2_v_r;
  logic               p3_v_r;
  logic [AREA_W-1:0]  p1_area_r;
  logic [AREA_W-1:0]  p2_area_r;
  logic [AREA_W-1:0]  p3_area_r;
  logic [3:0]         p2_bc_r [8];
  logic [3:0]         bc_nxt [8];
  logic [SCORE_W-1:0] p3_score_r;
  logic [SCORE_W-1:0] score_nxt;
  logic [PROBE_W-1:0] hit;

  assign hit = mask_eff & probe_r;

  // Popcount of each byte of the masked probe.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      bc_nxt[b] = '0;
      for (int j = 0; j < 8; j++) begin
        bc_nxt[b] = bc_nxt[b] + 4'(hit[8*b+j]);
      end
    end
  end

  // Sum of the byte counts.
  always_comb begin
    score_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      score_nxt = score_nxt + SCORE_W'(p2_bc_r[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.rd_scan;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_area_r  <= AREA_W'(scan_cnt_r);
    p2_area_r  <= p1_area_r;
    p3_area_r  <= p2_area_r;
    p2_bc_r    <= bc_nxt;
    p3_score_r <= score_nxt;
  end

  // Kept list, ascending by score, ties in arrival order.
  logic [AREA_W-1:0]  kept_area_r  [FANOUT_MAX];
  logic [SCORE_W-1:0] kept_score_r [FANOUT_MAX];
  logic [CW-1:0]      cnt_r;
  logic [AREA_W-1:0]  ka_ext [FANOUT_MAX+1];
  logic [SCORE_W-1:0] ks_ext [FANOUT_MAX+1];
  logic [AREA_W-1:0]  ra [FANOUT_MAX];
  logic [SCORE_W-1:0] rs [FANOUT_MAX];
  logic [AREA_W-1:0]  na [FANOUT_MAX];
  logic [SCORE_W-1:0] ns [FANOUT_MAX];
  logic [CW-1:0]      r_cnt;
  logic               full;
  logic               take;

  // Evict the last entry tied with the minimum when full, then insert the
  // new score after every entry that is not larger.
  always_comb begin
    logic               run;
    logic               lt;
    logic               prev_lt;
    logic [AREA_W-1:0]  prev_a;
    logic [SCORE_W-1:0] prev_s;
    full = (cnt_r == cap);
    for (int i = 0; i < FANOUT_MAX; i++) begin
      ka_ext[i] = kept_area_r[i];
      ks_ext[i] = kept_score_r[i];
    end
    ka_ext[FANOUT_MAX] = '0;
    ks_ext[FANOUT_MAX] = '0;
    take = !full || (p3_score_r > ks_ext[0]);
    for (int i = 0; i < FANOUT_MAX; i++) begin
      run = (CW'(i + 1) < cnt_r) && (ks_ext[i+1] == ks_ext[0]);
      if (full && !run) begin
        ra[i] = ka_ext[i+1];
        rs[i] = ks_ext[i+1];
      end else begin
        ra[i] = ka_ext[i];
        rs[i] = ks_ext[i];
      end
    end
    r_cnt   = full ? (cnt_r - CW'(1)) : cnt_r;
    prev_lt = 1'b1;
    prev_a  = '0;
    prev_s  = '0;
    for (int i = 0; i < FANOUT_MAX; i++) begin
      lt = (CW'(i) < r_cnt) && (rs[i] <= p3_score_r);
      if (lt) begin
        na[i] = ra[i];
        ns[i] = rs[i];
      end else if (prev_lt) begin
        na[i] = p3_area_r;
        ns[i] = p3_score_r;
      end else begin
        na[i] = prev_a;
        ns[i] = prev_s;
      end
      prev_lt = lt;
      prev_a  = ra[i];
      prev_s  = rs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v_r && take) begin
      kept_area_r  <= na;
      kept_score_r <= ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.list_clr) begin
      cnt_r <= '0;
    end else if (p3_v_r && take) begin
      cnt_r <= r_cnt + CW'(1);
    end
  end

  // Result word index.
  logic [LIW-1:0] emit_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.list_clr) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_adv) begin
      emit_idx_r <= emit_idx_r + LIW'(1);
    end
  end

  assign res_area  = kept_area_r[emit_idx_r];
  assign res_score = kept_score_r[emit_idx_r];

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.src_ok     = (int'(src_r) < AREA_COUNT);
    sts.route_none = (cap == '0) || (limit == '0);
    sts.scan_last  = (scan_cnt_r == (limit - AW'(1)));
    sts.pipe_busy  = p1_v_r || p2_v_r || p3_v_r;
    sts.list_empty = (cnt_r == '0);
    sts.emit_last  = ((CW'(emit_idx_r) + CW'(1)) == cnt_r);
  end

  // The list never holds more than its storage.
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= FANOUT_MAX)
    else $error("kept count exceeds list depth");

  // During a scan the list never shrinks.
  a_cnt_grow : assert property (@(posedge clk) disable iff (!rst_n)
    p3_v_r |=> (cnt_r >= $past(cnt_r)))
    else $error("kept count shrank during a scan");

  // A mask write back never overlaps scores in flight.
  a_wr_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_set |-> !(p1_v_r || p2_v_r || p3_v_r))
    else $error("mask write during a scan");

endmodule

`default_nettype wire

// ===== rtl/top_k_gated_router.sv =====
// Top-k gated router. A set word is accepted, then its mask is read and written
// back (not for an out-of-range area). A route word is accepted, then scans each
// area in use (one mask memory read per cycle), drains the score pipeline, then
// emits one result word per cycle while out_tready is high; no new word is taken
// until the last result. Reset clears the mask valid bits (all masks read as
// zero) and loads 64 areas in use and a fanout of 4; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module top_k_gated_router #(
  parameter int AREA_COUNT = 64,
  parameter int FANOUT_MAX = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: source_area[5:0], target_area[11:6], gate_on[12], probe[76:13]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tkgr_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: operation[0]
  input  wire logic [0:0]                       in_tuser,
  // out_tdata: area[5:0], score[12:6]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tkgr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tkgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tkgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tkgr_pkg::*;

  localparam int AW = $clog2(AREA_COUNT + 1);
  localparam int CW = $clog2(FANOUT_MAX + 1);

  logic [6:0]          areas_used_r;
  logic [3:0]          fanout_r;
  logic [AW-1:0]       limit;
  logic [CW-1:0]       cap;
  cmd_t                cmd;
  sts_t                sts;
  logic [AREA_W-1:0]   res_area;
  logic [SCORE_W-1:0]  res_score;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      areas_used_r <= AREAS_USED_RST;
      fanout_r     <= FANOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AREAS_USED: areas_used_r <= cfg_data[6:0];
        REG_FANOUT:     fanout_r     <= cfg_data[3:0];
        default:        ;
      endcase
    end
  end

  // Clamp the registers to the built sizes.
  always_comb begin
    if (int'(areas_used_r) > AREA_COUNT) begin
      limit = AW'(AREA_COUNT);
    end else begin
      limit = AW'(areas_used_r);
    end
    if (int'(fanout_r) > FANOUT_MAX) begin
      cap = CW'(FANOUT_MAX);
    end else begin
      cap = CW'(fanout_r);
    end
  end

  tkgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tkgr_datapath #(
    .AREA_COUNT (AREA_COUNT),
    .FANOUT_MAX (FANOUT_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .limit     (limit),
    .cap       (cap),
    .cmd       (cmd),
    .sts       (sts),
    .res_area  (res_area),
    .res_score (res_score)
  );

  // Result word packing.
  assign out_tdata = {(OUT_DATA_W - AREA_W - SCORE_W)'(0), res_score, res_area};
  assign out_tlast = sts.emit_last;

endmodule

`default_nettype wire
